FILE: rtl/core/ggvc_pkg.sv
// ----------------------------------------------------------------------------
// ggvc_pkg
// Shared types, constants and the arctangent table of the go-to-goal
// velocity controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ggvc_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_GOAL_X      = 2'd0;
    localparam logic [1:0] REG_GOAL_Y      = 2'd1;
    localparam logic [1:0] REG_GAIN        = 2'd2;
    localparam logic [1:0] REG_SPEED_LIMIT = 2'd3;

    localparam logic [15:0] GOAL_X_RESET      = 16'd4096;
    localparam logic [15:0] GOAL_Y_RESET      = 16'd4096;
    localparam logic [15:0] GAIN_RESET        = 16'd4096;
    localparam logic [15:0] SPEED_LIMIT_RESET = 16'd12288;

    localparam int CORDIC_STAGES_DEFAULT = 16;
    localparam int MAX_STAGES            = 24;
    localparam int GUARD_BITS            = 8;

    // Datapath widths. The vector grows by the CORDIC gain and sqrt(2),
    // the angle by pi plus the sum of the table.
    localparam int XW = 28;
    localparam int ZW = 29;
    localparam int BW = ZW - 11;      // bearing, Q5.13
    localparam int EW = BW + 1;       // bearing error
    localparam int PW = 51;           // magnitude times gain compensation
    localparam int DW = PW - 32;      // distance, Q7.12
    localparam int SW = 16 + DW;      // gain times distance

    localparam logic signed [ZW-1:0] PI_24    = ZW'(52707179);
    localparam logic [23:0]          KCOMP_24 = 24'd10188014;
    localparam logic [DW-1:0]        DIST_THRESH  = DW'(409);
    localparam logic [EW-1:0]        ANGLE_THRESH = EW'(819);

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [15:0]   heading;
    } ggvc_vec_t;

    // atan(2^-i) in units of 2^-24 rad, rounded to nearest.
    function automatic logic signed [ZW-1:0] ggvc_atan(input int unsigned idx);
        logic [23:0] val;
        case (idx)
            0:       val = 24'd13176795;
            1:       val = 24'd7778716;
            2:       val = 24'd4110060;
            3:       val = 24'd2086331;
            4:       val = 24'd1047214;
            5:       val = 24'd524117;
            6:       val = 24'd262123;
            7:       val = 24'd131069;
            8:       val = 24'd65536;
            9:       val = 24'd32768;
            10:      val = 24'd16384;
            11:      val = 24'd8192;
            12:      val = 24'd4096;
            13:      val = 24'd2048;
            14:      val = 24'd1024;
            15:      val = 24'd512;
            16:      val = 24'd256;
            17:      val = 24'd128;
            18:      val = 24'd64;
            19:      val = 24'd32;
            20:      val = 24'd16;
            21:      val = 24'd8;
            22:      val = 24'd4;
            23:      val = 24'd2;
            default: val = 24'd0;
        endcase
        return signed'({{(ZW-24){1'b0}}, val});
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/go_to_goal_velocity_controller.sv
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller
// Proportional go-to-goal steering: distance and bearing to a configured
// target through a pipelined vectoring CORDIC, then a turn or drive command.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  pose in   in_valid/in_stall    pose_x, pose_y, heading
//  command   out_valid/out_stall  forward_speed, turn_rate
//  config    cfg_we               cfg_index, cfg_data
//
// One item is taken every cycle unless in_stall is raised. The pipeline has
// one fold stage, one register per CORDIC rotation, and four stages for the
// gain compensation multiply, the thresholds, the speed multiply and the
// output register. Every stage has its own valid bit, so a stall on the
// output only backs up as far as the first empty stage. Reset clears the
// valid bits and loads the register defaults.
//
`default_nettype none

module go_to_goal_velocity_controller
    import ggvc_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] pose_x,
    input  wire logic [15:0] pose_y,
    input  wire logic [15:0] heading,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      forward_speed,
    output logic [15:0]      turn_rate,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int NUM_STAGES = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] goal_x_reg;
    logic [15:0] goal_y_reg;
    logic [15:0] gain_reg;
    logic [15:0] speed_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg      <= GOAL_X_RESET;
            goal_y_reg      <= GOAL_Y_RESET;
            gain_reg        <= GAIN_RESET;
            speed_limit_reg <= SPEED_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GOAL_X:      goal_x_reg      <= cfg_data;
                REG_GOAL_Y:      goal_y_reg      <= cfg_data;
                REG_GAIN:        gain_reg        <= cfg_data;
                REG_SPEED_LIMIT: speed_limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake chain, from the output back to the input
    // ------------------------------------------------------------------
    logic      vs  [0:NUM_STAGES];
    ggvc_vec_t ds  [0:NUM_STAGES];
    logic      rdy [0:NUM_STAGES];

    logic fold_ready;
    logic p1_ready;
    logic p2_ready;
    logic p3_ready;
    logic out_ready;

    logic p1_vld_reg;
    logic p2_vld_reg;
    logic p3_vld_reg;
    logic out_vld_reg;

    assign out_ready  = !out_vld_reg || !out_stall;
    assign p3_ready   = !p3_vld_reg || out_ready;
    assign p2_ready   = !p2_vld_reg || p3_ready;
    assign p1_ready   = !p1_vld_reg || p2_ready;
    assign rdy[NUM_STAGES] = p1_ready;
    assign fold_ready = !vs[0] || rdy[0];
    assign in_stall   = !fold_ready;

    // ------------------------------------------------------------------
    // Fold stage: goal minus pose, scaled, folded into the right half plane
    // ------------------------------------------------------------------
    logic signed [16:0]   dx;
    logic signed [16:0]   dy;
    logic signed [XW-1:0] xg;
    logic signed [XW-1:0] yg;
    logic                 fold_vld_reg;
    ggvc_vec_t            fold_reg;
    ggvc_vec_t            fold_next;

    assign dx = signed'({1'b0, goal_x_reg}) - signed'({1'b0, pose_x});
    assign dy = signed'({1'b0, goal_y_reg}) - signed'({1'b0, pose_y});
    assign xg = XW'(dx) <<< GUARD_BITS;
    assign yg = XW'(dy) <<< GUARD_BITS;

    always_comb
    begin
        fold_next.heading = heading;
        if (dx[16])
        begin
            fold_next.x = -xg;
            fold_next.y = -yg;
            fold_next.z = dy[16] ? -PI_24 : PI_24;
        end
        else
        begin
            fold_next.x = xg;
            fold_next.y = yg;
            fold_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_vld_reg <= 1'b0;
        end
        else if (fold_ready)
        begin
            fold_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && fold_ready)
        begin
            fold_reg <= fold_next;
        end
    end

    assign vs[0] = fold_vld_reg;
    assign ds[0] = fold_reg;

    // ------------------------------------------------------------------
    // CORDIC rotations, one register per stage
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_cordic
        ggvc_cordic_stage #(
            .STAGE_IDX (k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vs[k]),
            .in_data   (ds[k]),
            .in_ready  (rdy[k]),
            .out_valid (vs[k+1]),
            .out_data  (ds[k+1]),
            .out_ready (rdy[k+1])
        );
    end

    // ------------------------------------------------------------------
    // P1: gain compensation multiply, bearing rounding
    // ------------------------------------------------------------------
    logic [XW-2:0]        mag;
    logic signed [ZW-1:0] z_rnd;
    logic [PW-1:0]        p1_prod_reg;
    logic signed [BW-1:0] p1_bearing_reg;
    logic signed [15:0]   p1_heading_reg;

    assign mag   = ds[NUM_STAGES].x[XW-1] ? '0 : ds[NUM_STAGES].x[XW-2:0];
    assign z_rnd = ds[NUM_STAGES].z + ZW'(1024);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
        end
        else if (p1_ready)
        begin
            p1_vld_reg <= vs[NUM_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vs[NUM_STAGES] && p1_ready)
        begin
            p1_prod_reg    <= PW'(mag) * PW'(KCOMP_24);
            p1_bearing_reg <= BW'(z_rnd >>> 11);
            p1_heading_reg <= ds[NUM_STAGES].heading;
        end
    end

    // ------------------------------------------------------------------
    // P2: distance, bearing error and both thresholds
    // ------------------------------------------------------------------
    logic [PW-1:0]        dist_sum;
    logic [DW-1:0]        distance;
    logic signed [EW-1:0] err;
    logic [EW-1:0]        aerr;
    logic [DW-1:0]        p2_dist_reg;
    logic [EW-1:0]        p2_aerr_reg;
    logic                 p2_far_reg;
    logic                 p2_turn_reg;

    assign dist_sum = p1_prod_reg + (PW'(1) << 31);
    assign distance = dist_sum[PW-1:32];
    assign err      = EW'(p1_bearing_reg) - EW'(p1_heading_reg);
    assign aerr     = err[EW-1] ? EW'(-err) : EW'(err);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_vld_reg <= 1'b0;
        end
        else if (p2_ready)
        begin
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_vld_reg && p2_ready)
        begin
            p2_dist_reg <= distance;
            p2_aerr_reg <= aerr;
            p2_far_reg  <= distance > DIST_THRESH;
            p2_turn_reg <= aerr > ANGLE_THRESH;
        end
    end

    // ------------------------------------------------------------------
    // P3: gain times distance
    // ------------------------------------------------------------------
    logic [SW-1:0] p3_speed_prod_reg;
    logic [EW-1:0] p3_aerr_reg;
    logic          p3_far_reg;
    logic          p3_turn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_vld_reg <= 1'b0;
        end
        else if (p3_ready)
        begin
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_vld_reg && p3_ready)
        begin
            p3_speed_prod_reg <= SW'(gain_reg) * SW'(p2_dist_reg);
            p3_aerr_reg       <= p2_aerr_reg;
            p3_far_reg        <= p2_far_reg;
            p3_turn_reg       <= p2_turn_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: clamp and command select
    // ------------------------------------------------------------------
    logic [SW-13:0] speed;
    logic [15:0]    speed_clamped;
    logic [15:0]    rate_sat;
    logic [15:0]    forward_speed_next;
    logic [15:0]    turn_rate_next;
    logic [15:0]    forward_speed_reg;
    logic [15:0]    turn_rate_reg;

    assign speed         = p3_speed_prod_reg[SW-1:12];
    assign speed_clamped = (speed > (SW-12)'(speed_limit_reg)) ? speed_limit_reg : speed[15:0];
    assign rate_sat      = (p3_aerr_reg > EW'(16'hFFFF)) ? 16'hFFFF : p3_aerr_reg[15:0];

    always_comb
    begin
        forward_speed_next = '0;
        turn_rate_next     = '0;
        if (p3_far_reg)
        begin
            if (p3_turn_reg)
            begin
                turn_rate_next = rate_sat;
            end
            else
            begin
                forward_speed_next = speed_clamped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_vld_reg <= p3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p3_vld_reg && out_ready)
        begin
            forward_speed_reg <= forward_speed_next;
            turn_rate_reg     <= turn_rate_next;
        end
    end

    assign out_valid     = out_vld_reg;
    assign forward_speed = forward_speed_reg;
    assign turn_rate     = turn_rate_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ggvc_cordic_stage.sv
// ----------------------------------------------------------------------------
// ggvc_cordic_stage
// One registered vectoring CORDIC micro-rotation with its own valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ggvc_cordic_stage
    import ggvc_pkg::*;
#(
    parameter int STAGE_IDX = 0
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire ggvc_vec_t in_data,
    output logic           in_ready,
    output logic           out_valid,
    output ggvc_vec_t      out_data,
    input  wire logic      out_ready
);

    localparam logic signed [ZW-1:0] ATAN = ggvc_atan(STAGE_IDX);

    logic      vld_reg;
    ggvc_vec_t data_reg;
    ggvc_vec_t data_next;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    assign xs = in_data.x >>> STAGE_IDX;
    assign ys = in_data.y >>> STAGE_IDX;

    // A non-negative y rotates clockwise toward the x axis.
    always_comb
    begin
        data_next = in_data;
        if (!in_data.y[XW-1])
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + ATAN;
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - ATAN;
        end
    end

    assign in_ready = !vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire
